// ----- rtl/rpqv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpqv_pkg
// shared types, constants and tables of the rotated particle quad pipeline
// ----------------------------------------------------------------------------
package rpqv_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_STEPS        = 24;

    // cordic gain 0.6072529350 in q4.30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // half extent = round(p / 51200) = ((p + 25600) >> 11) / 25
    localparam logic [45:0] EXT_ROUND = 46'd25600;
    localparam logic [4:0]  EXT_DIV   = 5'd25;
    // reciprocal of 25 scaled by 2^26, exact for values below 2^21
    localparam logic [21:0] EXT_RECIP = 22'd2684355;

    localparam logic signed [38:0] SAT_HI = 39'sd8388607;
    localparam logic signed [38:0] SAT_LO = -39'sd8388608;

    typedef enum logic [3:0] {
        CFG_FRAME_WIDTH  = 4'd0,
        CFG_FRAME_HEIGHT = 4'd1,
        CFG_SCALE_X      = 4'd2,
        CFG_SCALE_Y      = 4'd3,
        CFG_PREMULTIPLY  = 4'd4,
        CFG_RANDOM_ANGLE = 4'd5,
        CFG_BATCH_MODE   = 4'd6,
        CFG_ATLAS_BASE   = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic [15:0]        size_percent;
        logic [15:0]        rotation_angle;
        logic [15:0]        angle_offset;
        logic [15:0]        random_fraction;
        logic [7:0]         color_red;
        logic [7:0]         color_green;
        logic [7:0]         color_blue;
        logic [7:0]         color_alpha;
        logic [15:0]        slot;
    } particle_t;

    typedef struct packed {
        logic signed [23:0] bottom_left_x;
        logic signed [23:0] bottom_left_y;
        logic signed [23:0] bottom_right_x;
        logic signed [23:0] bottom_right_y;
        logic signed [23:0] top_right_x;
        logic signed [23:0] top_right_y;
        logic signed [23:0] top_left_x;
        logic signed [23:0] top_left_y;
        logic [31:0]        packed_color;
        logic [16:0]        quad_index;
    } quad_t;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/rpqv_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpqv channel interfaces
// valid/ready channels for particle words in and quad words out
// ----------------------------------------------------------------------------
interface rpqv_particle_if;
    logic                valid;
    logic                ready;
    rpqv_pkg::particle_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rpqv_quad_if;
    logic            valid;
    logic            ready;
    rpqv_pkg::quad_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rotated_particle_quad_vertices_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_particle_quad_vertices_top
// turns one particle word into one rotated screen quad word
// ----------------------------------------------------------------------------
// Takes one particle word per clock and returns one quad word per clock
// while the quad channel is not stalled. An accepted word passes through
// CORDIC_STEPS + 5 register stages on its way to the quad channel: the
// capture stage loads at the accepting edge, then one stage per CORDIC
// iteration, then rounding/quadrant, multiply, corner offset and the output
// register. Every stage carries its own valid bit and moves whenever the
// stage after it is empty or moving, so bubbles close up and a stalled
// output only backs up the pipe once all stages are full. Configuration is
// sampled live by the stages and must only be written while the pipe is
// empty. The half extents run in a side path beside the CORDIC (two
// multiplies, then a divide by 25 in two reciprocal steps).
// ----------------------------------------------------------------------------
module rotated_particle_quad_vertices_top #(
    parameter int ANGLE_BITS   = rpqv_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = rpqv_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    rpqv_particle_if.sink      particle,
    rpqv_quad_if.source        quad
);

    localparam int N    = CORDIC_STEPS;
    localparam int RSTG = N + 1;     // rounding and quadrant map
    localparam int MSTG = N + 2;     // extent times sin/cos
    localparam int OSTG = N + 3;     // corner offsets
    localparam int LAST = N + 4;     // output register

    // keep the top ANGLE_BITS of the 32-bit angle
    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [1:0]         quadrant;
        logic [31:0]        color;
        logic [16:0]        quad_index;
    } side_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [12:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [15:0] scale_x_reg;
    logic [15:0] scale_y_reg;
    logic        premultiply_reg;
    logic        random_angle_reg;
    logic        batch_mode_reg;
    logic [15:0] atlas_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= '0;
            frame_height_reg <= '0;
            scale_x_reg      <= 16'd256;
            scale_y_reg      <= 16'd256;
            premultiply_reg  <= 1'b0;
            random_angle_reg <= 1'b0;
            batch_mode_reg   <= 1'b0;
            atlas_base_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (rpqv_pkg::cfg_index_t'(cfg_index))
                rpqv_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[12:0];
                rpqv_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[12:0];
                rpqv_pkg::CFG_SCALE_X:      scale_x_reg      <= cfg_data;
                rpqv_pkg::CFG_SCALE_Y:      scale_y_reg      <= cfg_data;
                rpqv_pkg::CFG_PREMULTIPLY:  premultiply_reg  <= cfg_data[0];
                rpqv_pkg::CFG_RANDOM_ANGLE: random_angle_reg <= cfg_data[0];
                rpqv_pkg::CFG_BATCH_MODE:   batch_mode_reg   <= cfg_data[0];
                rpqv_pkg::CFG_ATLAS_BASE:   atlas_base_reg   <= cfg_data;
                default:                    ;   // unused index, dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage valids and flow control
    // a stage loads when it is empty or the next stage loads
    // ------------------------------------------------------------------
    logic [LAST:0] valid_reg;
    logic [LAST:0] en;

    assign en[LAST] = !valid_reg[LAST] || quad.ready;

    genvar g;
    generate
        for (g = 0; g < LAST; g++)
        begin : g_en
            assign en[g] = !valid_reg[g] || en[g + 1];
        end
    endgenerate

    assign particle.ready = en[0];
    assign quad.valid     = valid_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= particle.valid;
            end
            for (int k = 1; k <= LAST; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: angle reduction, first extent multiply, color, quad index
    // ------------------------------------------------------------------
    logic [15:0]        sel_angle;
    logic [15:0]        neg_angle;
    logic [31:0]        angle32;
    logic [1:0]         quadrant;
    logic [31:0]        residual;
    logic [15:0]        mul_r, mul_g, mul_b;
    logic [15:0]        div_r, div_g, div_b;
    side_t              side_next;
    logic [28:0]        m1_next [2];

    always_comb
    begin
        sel_angle = random_angle_reg ? particle.data.random_fraction
                                     : particle.data.angle_offset;
        neg_angle = 16'd0 - (particle.data.rotation_angle + sel_angle);
        angle32   = {neg_angle, 16'h0000} & ANGLE_MASK;
        // nearest quadrant, residual within an eighth of a turn
        quadrant  = angle32[31:30] + {1'b0, angle32[29]};
        residual  = angle32 - {quadrant, 30'd0};

        // x / 255 = (x + (x >> 8) + 1) >> 8 for any product of two bytes
        mul_r = particle.data.color_red   * particle.data.color_alpha;
        mul_g = particle.data.color_green * particle.data.color_alpha;
        mul_b = particle.data.color_blue  * particle.data.color_alpha;
        div_r = mul_r + {8'd0, mul_r[15:8]} + 16'd1;
        div_g = mul_g + {8'd0, mul_g[15:8]} + 16'd1;
        div_b = mul_b + {8'd0, mul_b[15:8]} + 16'd1;

        side_next.px       = particle.data.center_x;
        side_next.py       = particle.data.center_y;
        side_next.quadrant = quadrant;
        if (premultiply_reg)
        begin
            side_next.color = {particle.data.color_alpha, div_b[15:8],
                               div_g[15:8], div_r[15:8]};
        end
        else
        begin
            side_next.color = {particle.data.color_alpha, particle.data.color_blue,
                               particle.data.color_green, particle.data.color_red};
        end
        if (batch_mode_reg)
        begin
            side_next.quad_index = {1'b0, particle.data.slot} + {1'b0, atlas_base_reg};
        end
        else
        begin
            side_next.quad_index = {1'b0, particle.data.slot};
        end

        m1_next[0] = frame_width_reg  * particle.data.size_percent;
        m1_next[1] = frame_height_reg * particle.data.size_percent;
    end

    logic signed [33:0] cx_reg [0:N];
    logic signed [33:0] cy_reg [0:N];
    logic signed [33:0] cz_reg [0:N];
    side_t              side_reg [0:LAST-1];
    logic [28:0]        m1_reg [2];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cx_reg[0]   <= rpqv_pkg::CORDIC_GAIN;
            cy_reg[0]   <= '0;
            cz_reg[0]   <= {{2{residual[31]}}, residual};
            side_reg[0] <= side_next;
            m1_reg[0]   <= m1_next[0];
            m1_reg[1]   <= m1_next[1];
        end
    end

    // side word follows the item down the pipe
    generate
        for (g = 1; g < LAST; g++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (en[g])
                begin
                    side_reg[g] <= side_reg[g - 1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // cordic, one iteration per stage
    // ------------------------------------------------------------------
    generate
        for (g = 1; g <= N; g++)
        begin : g_cordic
            localparam logic signed [33:0] ATAN =
                $signed({2'b00, rpqv_pkg::atan_turn(g - 1)});
            always_ff @(posedge clk)
            begin
                if (en[g])
                begin
                    if (!cz_reg[g - 1][33])
                    begin
                        cx_reg[g] <= cx_reg[g - 1] - (cy_reg[g - 1] >>> (g - 1));
                        cy_reg[g] <= cy_reg[g - 1] + (cx_reg[g - 1] >>> (g - 1));
                        cz_reg[g] <= cz_reg[g - 1] - ATAN;
                    end
                    else
                    begin
                        cx_reg[g] <= cx_reg[g - 1] + (cy_reg[g - 1] >>> (g - 1));
                        cy_reg[g] <= cy_reg[g - 1] - (cx_reg[g - 1] >>> (g - 1));
                        cz_reg[g] <= cz_reg[g - 1] + ATAN;
                    end
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // half extents beside the cordic, stages 1 to 4
    // ------------------------------------------------------------------
    logic [44:0] p_reg  [2];     // stage 1: frame * size * scale
    logic [18:0] vh_reg [2];     // stage 2: high part of the rounded quotient input
    logic [15:0] vl_reg [2];
    logic [14:0] qh_reg [2];
    logic [20:0] v2_reg [2];     // stage 3: remainder joined with low part
    logic [14:0] qh3_reg [2];
    logic [30:0] hx_reg [4:RSTG][2];

    logic [45:0] rnd_next  [2];
    logic [40:0] qh_prod   [2];
    logic [18:0] rh_next   [2];
    logic [42:0] q2_prod   [2];

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            rnd_next[a] = {1'b0, p_reg[a]} + rpqv_pkg::EXT_ROUND;
            qh_prod[a]  = rnd_next[a][45:27] * rpqv_pkg::EXT_RECIP;
            rh_next[a]  = vh_reg[a] - 19'(qh_reg[a] * rpqv_pkg::EXT_DIV);
            q2_prod[a]  = v2_reg[a] * rpqv_pkg::EXT_RECIP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p_reg[0] <= m1_reg[0] * scale_x_reg;
            p_reg[1] <= m1_reg[1] * scale_y_reg;
        end
        if (en[2])
        begin
            for (int a = 0; a < 2; a++)
            begin
                vh_reg[a] <= rnd_next[a][45:27];
                vl_reg[a] <= rnd_next[a][26:11];
                qh_reg[a] <= qh_prod[a][40:26];
            end
        end
        if (en[3])
        begin
            for (int a = 0; a < 2; a++)
            begin
                v2_reg[a]  <= {rh_next[a][4:0], vl_reg[a]};
                qh3_reg[a] <= qh_reg[a];
            end
        end
        if (en[4])
        begin
            for (int a = 0; a < 2; a++)
            begin
                hx_reg[4][a] <= {qh3_reg[a], q2_prod[a][41:26]};
            end
        end
    end

    generate
        for (g = 5; g <= RSTG; g++)
        begin : g_ext
            always_ff @(posedge clk)
            begin
                if (en[g])
                begin
                    hx_reg[g] <= hx_reg[g - 1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // rounding to q.16 and quadrant map
    // ------------------------------------------------------------------
    logic signed [33:0] xr_full, yr_full;
    logic signed [19:0] xr, yr;
    logic signed [19:0] cos_next, sin_next;
    logic signed [19:0] cos_reg, sin_reg;

    always_comb
    begin
        xr_full = (cx_reg[N] + 34'sd8192) >>> 14;
        yr_full = (cy_reg[N] + 34'sd8192) >>> 14;
        xr      = xr_full[19:0];
        yr      = yr_full[19:0];
        case (side_reg[N].quadrant)
            2'd0:    begin cos_next = xr;  sin_next = yr;  end
            2'd1:    begin cos_next = -yr; sin_next = xr;  end
            2'd2:    begin cos_next = -xr; sin_next = -yr; end
            default: begin cos_next = yr;  sin_next = -xr; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[RSTG])
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    // ------------------------------------------------------------------
    // extents times sin and cos: xc, xs, yc, ys
    // ------------------------------------------------------------------
    logic signed [51:0] xc_reg, xs_reg, yc_reg, ys_reg;

    always_ff @(posedge clk)
    begin
        if (en[MSTG])
        begin
            xc_reg <= $signed({1'b0, hx_reg[RSTG][0]}) * cos_reg;
            xs_reg <= $signed({1'b0, hx_reg[RSTG][0]}) * sin_reg;
            yc_reg <= $signed({1'b0, hx_reg[RSTG][1]}) * cos_reg;
            ys_reg <= $signed({1'b0, hx_reg[RSTG][1]}) * sin_reg;
        end
    end

    // ------------------------------------------------------------------
    // corner offsets, rounded from q.16
    // ------------------------------------------------------------------
    function automatic logic signed [37:0] round_off(input logic signed [53:0] v);
        logic signed [53:0] t;
        t = v + 54'sd32768;
        return t[53:16];
    endfunction

    logic signed [53:0] xc_w, xs_w, yc_w, ys_w;
    logic signed [37:0] off_reg [8];

    assign xc_w = 54'(xc_reg);
    assign xs_w = 54'(xs_reg);
    assign yc_w = 54'(yc_reg);
    assign ys_w = 54'(ys_reg);

    always_ff @(posedge clk)
    begin
        if (en[OSTG])
        begin
            off_reg[0] <= round_off(-xc_w + ys_w);   // bottom left
            off_reg[1] <= round_off(-xs_w - yc_w);
            off_reg[2] <= round_off(xc_w + ys_w);    // bottom right
            off_reg[3] <= round_off(xs_w - yc_w);
            off_reg[4] <= round_off(xc_w - ys_w);    // top right
            off_reg[5] <= round_off(xs_w + yc_w);
            off_reg[6] <= round_off(-xc_w - ys_w);   // top left
            off_reg[7] <= round_off(-xs_w + yc_w);
        end
    end

    // ------------------------------------------------------------------
    // add center, saturate, output register
    // ------------------------------------------------------------------
    function automatic logic signed [23:0] place(input logic signed [23:0] c,
                                                 input logic signed [37:0] o);
        logic signed [38:0] s;
        s = 39'(c) + 39'(o);
        if (s > rpqv_pkg::SAT_HI)
        begin
            return 24'sh7FFFFF;
        end
        else if (s < rpqv_pkg::SAT_LO)
        begin
            return 24'sh800000;
        end
        return s[23:0];
    endfunction

    rpqv_pkg::quad_t out_next;
    rpqv_pkg::quad_t out_reg;

    always_comb
    begin
        out_next.bottom_left_x  = place(side_reg[OSTG].px, off_reg[0]);
        out_next.bottom_left_y  = place(side_reg[OSTG].py, off_reg[1]);
        out_next.bottom_right_x = place(side_reg[OSTG].px, off_reg[2]);
        out_next.bottom_right_y = place(side_reg[OSTG].py, off_reg[3]);
        out_next.top_right_x    = place(side_reg[OSTG].px, off_reg[4]);
        out_next.top_right_y    = place(side_reg[OSTG].py, off_reg[5]);
        out_next.top_left_x     = place(side_reg[OSTG].px, off_reg[6]);
        out_next.top_left_y     = place(side_reg[OSTG].py, off_reg[7]);
        out_next.packed_color   = side_reg[OSTG].color;
        out_next.quad_index     = side_reg[OSTG].quad_index;
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            out_reg <= out_next;
        end
    end

    assign quad.data = out_reg;

`ifndef SYNTHESIS
    // an empty output register never holds back the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[LAST] |-> particle.ready)
        else $error("input stalled with empty output register");

    // a full pipe behind a stalled output takes nothing in
    assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg && !quad.ready) |-> !particle.ready)
        else $error("input accepted into a full stalled pipe");

    // the reciprocal divide leaves a remainder below 25
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> (v2_reg[0][20:16] < rpqv_pkg::EXT_DIV
                          && v2_reg[1][20:16] < rpqv_pkg::EXT_DIV))
        else $error("extent divide remainder out of range");

    // the residual angle has converged after the last iteration
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[N] |-> (cz_reg[N] < 34'sd16777216 && cz_reg[N] > -34'sd16777216))
        else $error("cordic residual did not converge");
`endif

endmodule

// ----- test/rotated_particle_quad_vertices_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_particle_quad_vertices_top_tb
// self-checking bench for the rotated particle quad pipeline
// ----------------------------------------------------------------------------
// Particle words are fed from a queue by a clocked driver and quad words are
// checked by a clocked monitor against a local predictor (half extents,
// cordic sine/cosine, corner rounding and saturation, color premultiply and
// quad index). Several register settings are run, written only while the
// pipe is empty.
// ----------------------------------------------------------------------------
module rotated_particle_quad_vertices_top_tb;

    localparam int  LATENCY     = rpqv_pkg::CORDIC_STEPS_DEF + 4;
    localparam int  CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [3:0] cfg_index;
    logic [15:0] cfg_data;

    rpqv_particle_if particle ();
    rpqv_quad_if     quad ();

    rotated_particle_quad_vertices_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .particle  (particle.sink),
        .quad      (quad.source)
    );

    // predictor copy of the registers
    logic [12:0] frame_w, frame_h;
    logic [15:0] tex_scale_x, tex_scale_y, atlas_first;
    logic        premul_on, random_on, batch_on;

    rpqv_pkg::particle_t particle_queue[$];
    rpqv_pkg::quad_t     pending_quads[$];
    int        errors;
    int        cycles;
    bit        idle_on;      // random idling enabled on both sides
    bit        hold_off_req; // ask the monitor for a long stall
    int        hold_count;

    const int ATAN_TURN[24] = '{536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
        333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652,
        326, 163, 81};

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rotated_particle_quad_vertices_top verification failed");
            $finish;
        end
    end

    function automatic longint rshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [23:0] clamp24(longint v);
        if (v > 8388607) return 24'h7fffff;
        if (v < -8388608) return 24'h800000;
        return v[23:0];
    endfunction

    // sine and cosine of a 32-bit binary angle, q.16
    task automatic cordic_sin_cos(input logic [31:0] a32, output longint co,
                                  output longint si);
        logic [1:0] quadrant;
        logic [31:0] resid;
        longint z, x, y, nx;
        quadrant = 2'((a32 + 32'h2000_0000) >> 30);
        resid = a32 - (32'(quadrant) << 30);
        z = longint'($signed(resid));
        x = 652032874;
        y = 0;
        for (int i = 0; i < rpqv_pkg::CORDIC_STEPS_DEF; i++)
        begin
            if (z >= 0)
            begin
                nx = x - rshift(y, i); y = y + rshift(x, i); z -= ATAN_TURN[i];
            end
            else
            begin
                nx = x + rshift(y, i); y = y - rshift(x, i); z += ATAN_TURN[i];
            end
            x = nx;
        end
        x = rshift(x + 8192, 14);
        y = rshift(y + 8192, 14);
        case (quadrant)
            2'd0: begin co = x;  si = y;  end
            2'd1: begin co = -y; si = x;  end
            2'd2: begin co = -x; si = -y; end
            default: begin co = y; si = -x; end
        endcase
    endtask

    task automatic predict_quad(input rpqv_pkg::particle_t p, output rpqv_pkg::quad_t q);
        longint hx, hy, c, s, xc, xs, yc, ys, cx, cy;
        logic [15:0] sel, ang;
        logic [7:0] r, g, b;
        hx = (longint'(frame_w) * p.size_percent * tex_scale_x + 25600) / 51200;
        hy = (longint'(frame_h) * p.size_percent * tex_scale_y + 25600) / 51200;
        sel = random_on ? p.random_fraction : p.angle_offset;
        ang = 16'd0 - (p.rotation_angle + sel);
        cordic_sin_cos({ang, 16'd0}, c, s);
        xc = hx * c; xs = hx * s; yc = hy * c; ys = hy * s;
        cx = longint'(p.center_x);
        cy = longint'(p.center_y);
        q.bottom_left_x  = clamp24(cx + rshift(-xc + ys + 32768, 16));
        q.bottom_left_y  = clamp24(cy + rshift(-xs - yc + 32768, 16));
        q.bottom_right_x = clamp24(cx + rshift(xc + ys + 32768, 16));
        q.bottom_right_y = clamp24(cy + rshift(xs - yc + 32768, 16));
        q.top_right_x    = clamp24(cx + rshift(xc - ys + 32768, 16));
        q.top_right_y    = clamp24(cy + rshift(xs + yc + 32768, 16));
        q.top_left_x     = clamp24(cx + rshift(-xc - ys + 32768, 16));
        q.top_left_y     = clamp24(cy + rshift(-xs + yc + 32768, 16));
        r = p.color_red; g = p.color_green; b = p.color_blue;
        if (premul_on)
        begin
            r = 8'((16'(r) * p.color_alpha) / 255);
            g = 8'((16'(g) * p.color_alpha) / 255);
            b = 8'((16'(b) * p.color_alpha) / 255);
        end
        q.packed_color = {p.color_alpha, b, g, r};
        q.quad_index = batch_on ? 17'(p.slot) + 17'(atlas_first) : 17'(p.slot);
    endtask

    // driver: offers queued words, random gaps while idling is enabled
    always @(posedge clk or negedge rst_n)
    begin
        rpqv_pkg::quad_t q;
        if (!rst_n)
            particle.valid <= 1'b0;
        else
        begin
            if (particle.valid && particle.ready)
            begin
                predict_quad(particle.data, q);
                pending_quads.push_back(q);
            end
            if (!particle.valid || particle.ready)
            begin
                if (particle_queue.size() > 0 && !(idle_on && $urandom_range(99) < 36))
                begin
                    particle.data  <= particle_queue.pop_front();
                    particle.valid <= 1'b1;
                end
                else
                    particle.valid <= 1'b0;
            end
        end
    end

    // monitor: random stalls plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        rpqv_pkg::quad_t e;
        if (!rst_n)
        begin
            quad.ready <= 1'b0;
            hold_count <= 0;
        end
        else
        begin
            if (quad.valid && quad.ready)
            begin
                if (pending_quads.size() == 0)
                begin
                    $display("%0t unexpected quad word %h", $time, quad.data);
                    errors++;
                end
                else
                begin
                    e = pending_quads.pop_front();
                    if (quad.data !== e)
                    begin
                        $display("%0t quad mismatch expected %h actual %h",
                                 $time, e, quad.data);
                        errors++;
                    end
                end
            end
            if (hold_off_req && hold_count == 0)
                hold_count <= 200;
            if (hold_count > 0)
            begin
                hold_count <= hold_count - 1;
                quad.ready <= 1'b0;
            end
            else
                quad.ready <= !(idle_on && $urandom_range(99) < 36);
        end
    end

    task automatic write_reg(input rpqv_pkg::cfg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            rpqv_pkg::CFG_FRAME_WIDTH:  frame_w = value[12:0];
            rpqv_pkg::CFG_FRAME_HEIGHT: frame_h = value[12:0];
            rpqv_pkg::CFG_SCALE_X:      tex_scale_x = value;
            rpqv_pkg::CFG_SCALE_Y:      tex_scale_y = value;
            rpqv_pkg::CFG_PREMULTIPLY:  premul_on = value[0];
            rpqv_pkg::CFG_RANDOM_ANGLE: random_on = value[0];
            rpqv_pkg::CFG_BATCH_MODE:   batch_on = value[0];
            default:                    atlas_first = value;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [12:0] fw, input logic [12:0] fh,
                             input logic [15:0] sx, input logic [15:0] sy,
                             input bit pm, input bit ra, input bit bm,
                             input logic [15:0] ab);
        write_reg(rpqv_pkg::CFG_FRAME_WIDTH, 16'(fw));
        write_reg(rpqv_pkg::CFG_FRAME_HEIGHT, 16'(fh));
        write_reg(rpqv_pkg::CFG_SCALE_X, sx);
        write_reg(rpqv_pkg::CFG_SCALE_Y, sy);
        write_reg(rpqv_pkg::CFG_PREMULTIPLY, 16'(pm));
        write_reg(rpqv_pkg::CFG_RANDOM_ANGLE, 16'(ra));
        write_reg(rpqv_pkg::CFG_BATCH_MODE, 16'(bm));
        write_reg(rpqv_pkg::CFG_ATLAS_BASE, ab);
    endtask

    task automatic wait_drained;
        while (particle_queue.size() > 0 || particle.valid || pending_quads.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic rpqv_pkg::particle_t random_particle();
        rpqv_pkg::particle_t p;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom};
        // mostly small sizes and centers near the origin so corners stay in range
        if ($urandom_range(3) != 0) p.size_percent = 16'($urandom_range(0, 8000));
        if ($urandom_range(2) != 0)
        begin
            p.center_x = 24'(int'($urandom_range(0, 400000)) - 200000);
            p.center_y = 24'(int'($urandom_range(0, 400000)) - 200000);
        end
        return p;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            particle_queue.push_back(random_particle());
    endtask

    initial
    begin
        rpqv_pkg::particle_t p;
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = rpqv_pkg::CFG_FRAME_WIDTH;
        cfg_data = 0;
        particle.data = '0;
        quad.ready = 0;
        errors = 0;
        cycles = 0;
        idle_on = 0;
        hold_off_req = 0;
        frame_w = 0; frame_h = 0; tex_scale_x = 256; tex_scale_y = 256;
        premul_on = 0; random_on = 0; batch_on = 0; atlas_first = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset settings give corners on the center
        p = '0;
        particle_queue.push_back(p);
        p.center_x = 24'h7fffff; p.center_y = 24'h800000;
        p.color_red = 8'hff; p.color_alpha = 8'hff; p.slot = 16'hffff;
        particle_queue.push_back(p);
        wait_drained();

        configure(13'd64, 13'd32, 16'd256, 16'd512, 1'b1, 1'b0, 1'b1, 16'hffff);
        for (int a = 0; a < 8; a++)
        begin
            p = '0;
            p.size_percent = 16'd25600;
            p.rotation_angle = 16'(a * 8192);
            p.angle_offset = 16'(a * 4096 + 1);
            p.color_red = 8'(a * 37); p.color_green = 8'hff;
            p.color_blue = 8'h80; p.color_alpha = 8'(a * 36);
            p.slot = 16'(a * 9000);
            particle_queue.push_back(p);
        end
        // huge extents saturate, frame above 4096 unclamped
        wait_drained();
        configure(13'h1fff, 13'h1fff, 16'hffff, 16'hffff, 1'b0, 1'b1, 1'b0, 16'd0);
        p = '0;
        p.size_percent = 16'hffff; p.random_fraction = 16'hffff;
        p.rotation_angle = 16'd1000;
        particle_queue.push_back(p);
        p.center_x = 24'h7fff00; p.center_y = 24'h800100;
        p.random_fraction = 16'h8000;
        particle_queue.push_back(p);
        wait_drained();

        // random phases, idling on, long stretch without idling first
        configure(13'd16, 13'd16, 16'd256, 16'd256, 1'b0, 1'b0, 1'b0, 16'd0);
        run_random(150);
        wait_drained();

        idle_on = 1;
        configure(13'd100, 13'd37, 16'd300, 16'd128, 1'b1, 1'b1, 1'b1, 16'd12345);
        hold_off_req = 1;
        run_random(300);
        wait (hold_count > 0);
        hold_off_req = 0;
        wait_drained();

        configure(13'd4096, 13'd0, 16'd0, 16'd65535, 1'b0, 1'b0, 1'b1, 16'hffff);
        run_random(300);
        wait_drained();

        configure(13'($urandom_range(0, 4096)), 13'($urandom_range(0, 4096)),
                  16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), 16'($urandom));
        run_random(300);
        wait_drained();

        configure(13'd1, 13'd4096, 16'd256, 16'd1, 1'b1, 1'b0, 1'b0, 16'd0);
        run_random(285);
        wait_drained();

        if (errors == 0)
            $display("rotated_particle_quad_vertices_top verification clean");
        else
            $display("rotated_particle_quad_vertices_top verification failed");
        $finish;
    end
endmodule

// ----- rotated_particle_quad_vertices_top.f -----
rtl/rpqv_pkg.sv
rtl/rpqv_if.sv
rtl/rotated_particle_quad_vertices_top.sv
test/rotated_particle_quad_vertices_top_tb.sv
